/* rtl/lbmc_pkg.sv */
// Package for the LED bar meter controller.
// Holds mode, request and register codes, widths and the reset brightness ramp.
// No dependencies.
package lbmc_pkg;

  localparam int LED_COUNT_DEF = 16;
  localparam int LED_MAX       = 16;

  typedef logic [7:0]  level_t;
  typedef logic [1:0]  mode_t;
  typedef logic [1:0]  req_t;
  typedef logic [15:0] pattern_t;

  localparam mode_t MODE_RAW  = 2'd0;
  localparam mode_t MODE_VU   = 2'd1;
  localparam mode_t MODE_DEMO = 2'd2;

  localparam req_t REQ_CTRL = 2'd0;
  localparam req_t REQ_DISP = 2'd1;
  localparam req_t REQ_ADC  = 2'd2;

  localparam logic [1:0] ADC_OFF  = 2'd0;
  localparam logic [1:0] ADC_FREE = 2'd1;
  localparam logic [1:0] ADC_TRIG = 2'd2;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_PULSE    = 2'd1;
  localparam logic [1:0] REG_SLICE    = 2'd2;

  localparam level_t   DEBOUNCE_RST = 8'd16;
  localparam logic [15:0] PULSE_RST = 16'd323;
  localparam level_t   SLICE_RST    = 8'd16;

  function automatic level_t ramp_init(input logic [3:0] i);
    level_t v;
    v = (i == 4'd15) ? 8'd255 : 8'({4'd0, i} * {4'd0, i});
    return v;
  endfunction

  function automatic logic [1:0] adc_mode_of(input mode_t m);
    logic [1:0] r;
    unique case (m)
      MODE_VU:  r = ADC_FREE;
      MODE_RAW: r = ADC_TRIG;
      default:  r = ADC_OFF;
    endcase
    return r;
  endfunction

endpackage

/* rtl/led_bar_meter_controller.sv */
// LED bar meter controller top level: mode sequencer, pulse redraw, PWM slicing.
// One shared subtractor walks the brightness entries one LED per cycle.
// Depends on lbmc_pkg.
//
//   channel   direction  handshake               payload
//   in_       input      in_valid / in_stall     in_req_type, in_button_pressed, in_adc_value
//   out_      output     out_valid / out_stall   out_led_pattern, out_pattern_valid,
//                                                 out_current_mode, out_adc_mode
//   config    input      psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// An item goes from idle straight to done, or, for an attract control or display
// tick, through a pulse or slice pass in which the shared subtractor visits one brightness entry a cycle.
// in_stall is high while an item is at work; a finished result waits in the
// output register, and a new item is taken while it waits.
// Reset loads the brightness ramp and starts in attract mode.
module led_bar_meter_controller #(
  parameter int LED_COUNT = lbmc_pkg::LED_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lbmc_pkg::req_t     in_req_type,
  input  logic               in_button_pressed,
  input  logic [9:0]         in_adc_value,
  output logic               out_valid,
  input  logic               out_stall,
  output lbmc_pkg::pattern_t out_led_pattern,
  output logic               out_pattern_valid,
  output lbmc_pkg::mode_t    out_current_mode,
  output logic [1:0]         out_adc_mode,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lbmc_pkg::*;

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LED_COUNT - 1);
  localparam pattern_t LED_MASK = pattern_t'((17'd1 << LED_COUNT) - 17'd1);
  localparam int DW = 13;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PULSE = 2'd1;
  localparam logic [1:0] ST_SLICE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  level_t           debounce_r, slice_step_r;
  logic [15:0]      pulse_step_r;
  mode_t            mode_r, mode_nxt;
  level_t           holdoff_r, holdoff_nxt;
  logic [15:0]      pulse_r, pulse_nxt;
  level_t           slice_r, slice_nxt;
  level_t           bright_r [LED_COUNT];
  pattern_t         res_pattern_r, res_pattern_nxt;
  logic             res_valid_r, res_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  pattern_t         out_pattern_r;
  logic             out_pvalid_r;
  mode_t            out_mode_r;
  logic [1:0]       out_adc_r;

  logic             cfg_wr, accept, load_out, attract_now, attract_after;
  logic [DW-1:0]    op_a, op_b, diff, span;
  level_t           bright_new, sel_bright;
  logic [3:0]       bar_n;
  logic [3:0]       idx_ext;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign accept   = in_valid & ~in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign load_out = (state_r == ST_DONE) & (~out_valid_r | ~out_stall);
  assign idx_ext  = 4'(idx_r);
  assign sel_bright = bright_r[idx_r];
  assign attract_now = (mode_r != MODE_RAW) && (mode_r != MODE_VU);

  always_comb begin
    unique case (paddr[3:2])
      REG_DEBOUNCE: prdata = {24'd0, debounce_r};
      REG_PULSE:    prdata = {16'd0, pulse_step_r};
      REG_SLICE:    prdata = {24'd0, slice_step_r};
      default:      prdata = 32'd0;
    endcase
  end

  // shared subtractor: pulse distance or slice compare
  always_comb begin
    if (state_r == ST_PULSE) begin
      op_a = DW'({idx_ext, 8'h00});
      op_b = DW'(pulse_r[15:4]);
    end else begin
      op_a = DW'(slice_r);
      op_b = DW'(sel_bright);
    end
    diff = op_a - op_b;
    span = diff[DW-1] ? (~diff + DW'(1)) : diff;
    bright_new = (span >= DW'(255)) ? 8'd0 : 8'(DW'(255) - span);
  end

  assign bar_n = (mode_r == MODE_RAW) ? in_adc_value[9:6] : in_adc_value[5:2];

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    mode_nxt        = mode_r;
    holdoff_nxt     = holdoff_r;
    pulse_nxt       = pulse_r;
    slice_nxt       = slice_r;
    res_pattern_nxt = res_pattern_r;
    res_valid_nxt   = res_valid_r;
    out_valid_nxt   = out_valid_r & out_stall;
    attract_after   = attract_now;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_pattern_nxt = '0;
          res_valid_nxt   = 1'b0;
          idx_nxt         = '0;
          state_nxt       = ST_DONE;
          unique case (in_req_type)
            REQ_CTRL: begin
              if (in_button_pressed) begin
                if (holdoff_r == 8'd0) begin
                  holdoff_nxt   = debounce_r;
                  mode_nxt      = attract_now ? MODE_RAW : mode_r + 2'd1;
                  attract_after = (mode_nxt == MODE_DEMO);
                end
              end else if (holdoff_r != 8'd0) begin
                holdoff_nxt = holdoff_r - 8'd1;
              end
              if (attract_after) begin
                pulse_nxt = pulse_r + pulse_step_r;
                state_nxt = ST_PULSE;
              end
            end
            REQ_DISP: begin
              if (attract_now) begin
                slice_nxt     = slice_r + slice_step_r;
                res_valid_nxt = 1'b1;
                state_nxt     = ST_SLICE;
              end
            end
            REQ_ADC: begin
              if (!attract_now) begin
                res_pattern_nxt = pattern_t'((17'd1 << bar_n) - 17'd1) & LED_MASK;
                res_valid_nxt   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PULSE, ST_SLICE: begin
        if (state_r == ST_SLICE) begin
          res_pattern_nxt[idx_ext] = diff[DW-1];
        end
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      debounce_r   <= DEBOUNCE_RST;
      pulse_step_r <= PULSE_RST;
      slice_step_r <= SLICE_RST;
      mode_r       <= MODE_DEMO;
      holdoff_r    <= 8'd0;
      pulse_r      <= 16'd0;
      slice_r      <= 8'd0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < LED_COUNT; i++) begin
        bright_r[i] <= ramp_init(4'(i));
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      mode_r      <= mode_nxt;
      holdoff_r   <= holdoff_nxt;
      pulse_r     <= pulse_nxt;
      slice_r     <= slice_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_PULSE) begin
        bright_r[idx_r] <= bright_new;
      end
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_DEBOUNCE: debounce_r   <= pwdata[7:0];
          REG_PULSE:    pulse_step_r <= pwdata[15:0];
          REG_SLICE:    slice_step_r <= pwdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_pattern_r <= res_pattern_nxt;
    res_valid_r   <= res_valid_nxt;
    if (load_out) begin
      out_pattern_r <= res_pattern_r;
      out_pvalid_r  <= res_valid_r;
      out_mode_r    <= mode_r;
      out_adc_r     <= adc_mode_of(mode_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led_pattern   = out_pattern_r;
  assign out_pattern_valid = out_pvalid_r;
  assign out_current_mode  = out_mode_r;
  assign out_adc_mode      = out_adc_r;

endmodule
